// ----- rtl/core/siu_pkg.sv -----
// Shared constants for the segment intersection unit.
package siu_pkg;

    // Width of the parallel limit register
    localparam int LIMIT_W = 20;

    // Divider lanes
    localparam int LANES   = 4;
    localparam int LANE_X  = 0;
    localparam int LANE_Y  = 1;
    localparam int LANE_T1 = 2;
    localparam int LANE_T2 = 3;

endpackage

// ----- rtl/core/siu_if.sv -----
// Valid/ready channel interfaces for segment pairs and intersection results.
interface siu_seg_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] src_start_x;
    logic signed [COORD_BITS-1:0] src_start_y;
    logic signed [COORD_BITS-1:0] src_end_x;
    logic signed [COORD_BITS-1:0] src_end_y;
    logic signed [COORD_BITS-1:0] clip_start_x;
    logic signed [COORD_BITS-1:0] clip_start_y;
    logic signed [COORD_BITS-1:0] clip_end_x;
    logic signed [COORD_BITS-1:0] clip_end_y;

    modport source (
        output valid, src_start_x, src_start_y, src_end_x, src_end_y,
               clip_start_x, clip_start_y, clip_end_x, clip_end_y,
        input  ready
    );
    modport sink (
        input  valid, src_start_x, src_start_y, src_end_x, src_end_y,
               clip_start_x, clip_start_y, clip_end_x, clip_end_y,
        output ready
    );
endinterface

interface siu_res_if #(
    parameter int COORD_BITS  = 24,
    parameter int T_FRAC_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic                         interior;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
    logic [T_FRAC_BITS:0]         t_source;
    logic [T_FRAC_BITS:0]         t_clip;

    modport source (
        output valid, hit, interior, cross_x, cross_y, t_source, t_clip,
        input  ready
    );
    modport sink (
        input  valid, hit, interior, cross_x, cross_y, t_source, t_clip,
        output ready
    );
endinterface

// ----- rtl/core/segment_intersection_unit_top.sv -----
// Top level of the segment intersection unit: front tests, divider pipeline, output stage.
//
//   channel  | dir | handshake        | payload
//   seg      | in  | valid/ready      | two segments, eight signed coordinates
//   res      | out | valid/ready      | hit, interior, cross point, two parameters
//   cfg      | in  | cfg_we           | parallel_limit, 20 bits
//
// One item enters per cycle while the result is not stalled. The divider works on MB multiplier
// bits, MB = max(COORD_BITS, T_FRAC_BITS) + 1, and retires one multiplier bit per stage.
// rst_n clears all valid bits and sets parallel_limit to zero.
// A stalled result freezes the whole pipeline; items are held, none lost or repeated.
module segment_intersection_unit_top #(
    parameter int COORD_BITS  = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [siu_pkg::LIMIT_W-1:0] cfg_wdata,
    siu_seg_if.sink                     seg,
    siu_res_if.source                   res
);
    localparam int CW  = COORD_BITS;
    localparam int UW  = 2 * (CW + 1);
    localparam int RW  = UW + 2;
    localparam int MB  = (COORD_BITS > T_FRAC_BITS) ? COORD_BITS + 1 : T_FRAC_BITS + 1;
    localparam int MW  = MB;
    localparam int QW  = MB + 1;
    localparam int SBW = 4 + 2 * CW;
    localparam logic [MW-1:0] T_ONE = MW'(1) << T_FRAC_BITS;

    logic                        adv;
    logic [siu_pkg::LIMIT_W-1:0] limit_reg;

    logic                 g_valid, g_miss, g_inner, g_negx, g_negy;
    logic signed [CW-1:0] g_bx, g_by;
    logic [CW-1:0]        g_ax, g_ay;
    logic [UW-1:0]        g_den, g_u1, g_u2;

    logic                                  dv   [MB+1];
    logic [siu_pkg::LANES-1:0][RW-1:0]     dr   [MB+1];
    logic [siu_pkg::LANES-1:0][QW-1:0]     dq   [MB+1];
    logic [siu_pkg::LANES-1:0][UW-1:0]     da   [MB+1];
    logic [siu_pkg::LANES-1:0][MW-1:0]     dm   [MB+1];
    logic [UW-1:0]                         dden [MB+1];
    logic [SBW-1:0]                        dsb  [MB+1];

    logic                         out_valid_reg, hit_reg, interior_reg;
    logic signed [CW-1:0]         cx_reg, cy_reg;
    logic [T_FRAC_BITS:0]         ts_reg, tc_reg;
    logic [siu_pkg::LANES-1:0][QW-1:0] qf;
    logic                         f_miss, f_inner, f_negx, f_negy;
    logic signed [CW-1:0]         f_bx, f_by;

    // Advance the whole pipeline unless the result is stalled
    assign adv       = !out_valid_reg || res.ready;
    assign seg.ready = adv;

    // Hold the parallel limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    siu_geom #(
        .CW (CW),
        .UW (UW)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (seg.valid),
        .s1x       (seg.src_start_x),
        .s1y       (seg.src_start_y),
        .s2x       (seg.src_end_x),
        .s2y       (seg.src_end_y),
        .c1x       (seg.clip_start_x),
        .c1y       (seg.clip_start_y),
        .c2x       (seg.clip_end_x),
        .c2y       (seg.clip_end_y),
        .limit     (limit_reg),
        .out_valid (g_valid),
        .miss      (g_miss),
        .inner     (g_inner),
        .negx      (g_negx),
        .negy      (g_negy),
        .base_x    (g_bx),
        .base_y    (g_by),
        .ax        (g_ax),
        .ay        (g_ay),
        .den       (g_den),
        .u1        (g_u1),
        .u2        (g_u2)
    );

    // Load the divider lanes
    assign dv[0]   = g_valid;
    assign dr[0]   = '0;
    assign dq[0]   = '0;
    assign da[0]   = {g_u2, g_u1, g_u1, g_u1};
    assign dm[0]   = {T_ONE, T_ONE, MW'(g_ay), MW'(g_ax)};
    assign dden[0] = g_den;
    assign dsb[0]  = {g_miss, g_inner, g_negx, g_negy, g_bx, g_by};

    for (genvar i = 0; i < MB; i++)
    begin : g_div
        siu_div_stage #(
            .MW  (MW),
            .UW  (UW),
            .RW  (RW),
            .QW  (QW),
            .SBW (SBW),
            .BIT (MB - 1 - i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv[i]),
            .in_r      (dr[i]),
            .in_q      (dq[i]),
            .in_a      (da[i]),
            .in_m      (dm[i]),
            .in_den    (dden[i]),
            .in_sb     (dsb[i]),
            .out_valid (dv[i+1]),
            .out_r     (dr[i+1]),
            .out_q     (dq[i+1]),
            .out_a     (da[i+1]),
            .out_m     (dm[i+1]),
            .out_den   (dden[i+1]),
            .out_sb    (dsb[i+1])
        );
    end

    // Round each quotient to nearest
    always_comb
    begin
        {f_miss, f_inner, f_negx, f_negy, f_bx, f_by} = dsb[MB];
        for (int l = 0; l < siu_pkg::LANES; l++)
        begin
            qf[l] = dq[MB][l] +
                    QW'({dr[MB][l], 1'b0} >= {1'b0, RW'(dden[MB])});
        end
    end

    // Hold result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv[MB];
    end

    // Apply offsets and drop everything on a miss
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg      <= !f_miss;
            interior_reg <= !f_miss && f_inner;
            cx_reg       <= f_miss ? '0 :
                            (f_negx ? f_bx - CW'(qf[siu_pkg::LANE_X])
                                    : f_bx + CW'(qf[siu_pkg::LANE_X]));
            cy_reg       <= f_miss ? '0 :
                            (f_negy ? f_by - CW'(qf[siu_pkg::LANE_Y])
                                    : f_by + CW'(qf[siu_pkg::LANE_Y]));
            ts_reg       <= f_miss ? '0 : qf[siu_pkg::LANE_T1][T_FRAC_BITS:0];
            tc_reg       <= f_miss ? '0 : qf[siu_pkg::LANE_T2][T_FRAC_BITS:0];
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.hit      = hit_reg;
    assign res.interior = interior_reg;
    assign res.cross_x  = cx_reg;
    assign res.cross_y  = cy_reg;
    assign res.t_source = ts_reg;
    assign res.t_clip   = tc_reg;
endmodule

// ----- rtl/core/siu_geom.sv -----
// Front pipeline: differences, cross products, denominator and exact range tests.
module siu_geom #(
    parameter int CW = 24,
    parameter int UW = 50
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] s1x,
    input  logic signed [CW-1:0] s1y,
    input  logic signed [CW-1:0] s2x,
    input  logic signed [CW-1:0] s2y,
    input  logic signed [CW-1:0] c1x,
    input  logic signed [CW-1:0] c1y,
    input  logic signed [CW-1:0] c2x,
    input  logic signed [CW-1:0] c2y,
    input  logic [siu_pkg::LIMIT_W-1:0] limit,
    output logic                 out_valid,
    output logic                 miss,
    output logic                 inner,
    output logic                 negx,
    output logic                 negy,
    output logic signed [CW-1:0] base_x,
    output logic signed [CW-1:0] base_y,
    output logic [CW-1:0]        ax,
    output logic [CW-1:0]        ay,
    output logic [UW-1:0]        den,
    output logic [UW-1:0]        u1,
    output logic [UW-1:0]        u2
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int NW = UW + 1;

    // Stage 1: coordinate differences
    logic                 v1_reg;
    logic signed [DW-1:0] dxs_reg, dys_reg, dxc_reg, dyc_reg, ox_reg, oy_reg;
    logic signed [CW-1:0] s1x_reg, s1y_reg;

    // Stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] pd1_reg, pd2_reg, pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic signed [DW-1:0] dxs2_reg, dys2_reg;
    logic signed [CW-1:0] s1x2_reg, s1y2_reg;

    // Stage 3: denominator and numerators
    logic                 v3_reg;
    logic signed [NW-1:0] d_reg, n1_reg, n2_reg;
    logic signed [DW-1:0] dxs3_reg, dys3_reg;
    logic signed [CW-1:0] s1x3_reg, s1y3_reg;

    // Stage 4: tests
    logic                 v4_reg;
    logic                 miss_reg, inner_reg, negx_reg, negy_reg;
    logic signed [CW-1:0] bx_reg, by_reg;
    logic [CW-1:0]        ax_reg, ay_reg;
    logic [UW-1:0]        den_reg, u1_reg, u2_reg;

    logic signed [PW-1:0] pd1_next, pd2_next, pa1_next, pa2_next, pb1_next, pb2_next;
    logic signed [NW-1:0] nn1, nn2;
    logic [UW-1:0]        mag, m1, m2;
    logic [DW-1:0]        adx, ady;
    logic                 par, out_rng;

    assign pd1_next = dyc_reg * dxs_reg;
    assign pd2_next = dxc_reg * dys_reg;
    assign pa1_next = dxc_reg * oy_reg;
    assign pa2_next = dyc_reg * ox_reg;
    assign pb1_next = dxs_reg * oy_reg;
    assign pb2_next = dys_reg * ox_reg;

    // Normalize sign of the denominator and test both parameters
    always_comb
    begin
        mag     = d_reg[NW-1] ? UW'(-d_reg) : UW'(d_reg);
        nn1     = d_reg[NW-1] ? -n1_reg : n1_reg;
        nn2     = d_reg[NW-1] ? -n2_reg : n2_reg;
        m1      = UW'(nn1);
        m2      = UW'(nn2);
        par     = mag <= UW'(limit);
        out_rng = nn1[NW-1] || nn2[NW-1] || (m1 > mag) || (m2 > mag);
        adx     = dxs3_reg[DW-1] ? DW'(-dxs3_reg) : DW'(dxs3_reg);
        ady     = dys3_reg[DW-1] ? DW'(-dys3_reg) : DW'(dys3_reg);
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxs_reg   <= DW'(s2x) - DW'(s1x);
            dys_reg   <= DW'(s2y) - DW'(s1y);
            dxc_reg   <= DW'(c2x) - DW'(c1x);
            dyc_reg   <= DW'(c2y) - DW'(c1y);
            ox_reg    <= DW'(s1x) - DW'(c1x);
            oy_reg    <= DW'(s1y) - DW'(c1y);
            s1x_reg   <= s1x;
            s1y_reg   <= s1y;

            pd1_reg   <= pd1_next;
            pd2_reg   <= pd2_next;
            pa1_reg   <= pa1_next;
            pa2_reg   <= pa2_next;
            pb1_reg   <= pb1_next;
            pb2_reg   <= pb2_next;
            dxs2_reg  <= dxs_reg;
            dys2_reg  <= dys_reg;
            s1x2_reg  <= s1x_reg;
            s1y2_reg  <= s1y_reg;

            d_reg     <= NW'(pd1_reg) - NW'(pd2_reg);
            n1_reg    <= NW'(pa1_reg) - NW'(pa2_reg);
            n2_reg    <= NW'(pb1_reg) - NW'(pb2_reg);
            dxs3_reg  <= dxs2_reg;
            dys3_reg  <= dys2_reg;
            s1x3_reg  <= s1x2_reg;
            s1y3_reg  <= s1y2_reg;

            miss_reg  <= par || out_rng;
            inner_reg <= (m1 != '0) && (m1 < mag) && (m2 != '0) && (m2 < mag);
            negx_reg  <= dxs3_reg[DW-1];
            negy_reg  <= dys3_reg[DW-1];
            bx_reg    <= s1x3_reg;
            by_reg    <= s1y3_reg;
            ax_reg    <= CW'(adx);
            ay_reg    <= CW'(ady);
            den_reg   <= mag;
            u1_reg    <= m1;
            u2_reg    <= m2;
        end
    end

    assign out_valid = v4_reg;
    assign miss      = miss_reg;
    assign inner     = inner_reg;
    assign negx      = negx_reg;
    assign negy      = negy_reg;
    assign base_x    = bx_reg;
    assign base_y    = by_reg;
    assign ax        = ax_reg;
    assign ay        = ay_reg;
    assign den       = den_reg;
    assign u1        = u1_reg;
    assign u2        = u2_reg;
endmodule

// ----- rtl/core/siu_div_stage.sv -----
// One registered step of the multiply-divide pipeline: one multiplier bit for all lanes.
module siu_div_stage #(
    parameter int MW  = 25,
    parameter int UW  = 50,
    parameter int RW  = 52,
    parameter int QW  = 26,
    parameter int SBW = 52,
    parameter int BIT = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic [siu_pkg::LANES-1:0][RW-1:0]      in_r,
    input  logic [siu_pkg::LANES-1:0][QW-1:0]      in_q,
    input  logic [siu_pkg::LANES-1:0][UW-1:0]      in_a,
    input  logic [siu_pkg::LANES-1:0][MW-1:0]      in_m,
    input  logic [UW-1:0]                          in_den,
    input  logic [SBW-1:0]                         in_sb,
    output logic                                   out_valid,
    output logic [siu_pkg::LANES-1:0][RW-1:0]      out_r,
    output logic [siu_pkg::LANES-1:0][QW-1:0]      out_q,
    output logic [siu_pkg::LANES-1:0][UW-1:0]      out_a,
    output logic [siu_pkg::LANES-1:0][MW-1:0]      out_m,
    output logic [UW-1:0]                          out_den,
    output logic [SBW-1:0]                         out_sb
);
    logic                                  v_reg;
    logic [siu_pkg::LANES-1:0][RW-1:0]     r_reg, r_next;
    logic [siu_pkg::LANES-1:0][QW-1:0]     q_reg, q_next;
    logic [siu_pkg::LANES-1:0][UW-1:0]     a_reg;
    logic [siu_pkg::LANES-1:0][MW-1:0]     m_reg;
    logic [UW-1:0]                         den_reg;
    logic [SBW-1:0]                        sb_reg;
    logic [RW-1:0]                         den1, den2;
    logic [RW-1:0]                         r2;

    assign den1 = RW'(in_den);
    assign den2 = {den1[RW-2:0], 1'b0};

    // Shift in one multiplier bit and reduce the remainder below the divisor
    always_comb
    begin
        r_next = '0;
        q_next = '0;
        r2     = '0;
        for (int l = 0; l < siu_pkg::LANES; l++)
        begin
            r2 = {in_r[l][RW-2:0], 1'b0} + (in_m[l][BIT] ? RW'(in_a[l]) : '0);
            if (r2 >= den2)
            begin
                r_next[l] = r2 - den2;
                q_next[l] = {in_q[l][QW-2:0], 1'b0} + QW'(2);
            end
            else if (r2 >= den1)
            begin
                r_next[l] = r2 - den1;
                q_next[l] = {in_q[l][QW-2:0], 1'b0} + QW'(1);
            end
            else
            begin
                r_next[l] = r2;
                q_next[l] = {in_q[l][QW-2:0], 1'b0};
            end
        end
    end

    // Hold valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (adv)
            v_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg   <= r_next;
            q_reg   <= q_next;
            a_reg   <= in_a;
            m_reg   <= in_m;
            den_reg <= in_den;
            sb_reg  <= in_sb;
        end
    end

    assign out_valid = v_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;
    assign out_a     = a_reg;
    assign out_m     = m_reg;
    assign out_den   = den_reg;
    assign out_sb    = sb_reg;
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the segment intersection unit.
`timescale 1ns / 1ps

// Predicts intersection results and checks them in order of acceptance.
class intersect_scoreboard;
    typedef struct packed {
        logic               hit;
        logic               interior;
        logic signed [23:0] cross_x;
        logic signed [23:0] cross_y;
        logic [16:0]        t_source;
        logic [16:0]        t_clip;
    } outcome_t;

    outcome_t pending[$];
    logic [19:0] limit_reg;
    int mismatches;
    int checked;
    int hits;
    int interiors;

    function new();
        limit_reg = '0;
        mismatches = 0;
        checked = 0;
        hits = 0;
        interiors = 0;
    endfunction

    // round(a*m/den), halves up
    static function longint unsigned scaled_round(longint unsigned a, longint unsigned m,
                                                  longint unsigned den);
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] r;
        prod = 128'(a) * 128'(m);
        q = prod / den;
        r = prod % den;
        if (2 * r >= den)
            q = q + 1;
        return q[63:0];
    endfunction

    static function longint interp_axis(longint start, longint delta, longint unsigned n,
                                        longint unsigned den);
        longint unsigned off;
        off = scaled_round(n, (delta < 0) ? -delta : delta, den);
        return (delta < 0) ? start - longint'(off) : start + longint'(off);
    endfunction

    // Note an accepted segment pair and queue its expected outcome.
    function void note_pair(logic signed [23:0] c[8]);
        longint dxs, dys, dxc, dyc, ox, oy, d, n1, n2, mag;
        outcome_t o;
        bit inner;
        o = '0;
        dxs = longint'(c[2]) - longint'(c[0]);
        dys = longint'(c[3]) - longint'(c[1]);
        dxc = longint'(c[6]) - longint'(c[4]);
        dyc = longint'(c[7]) - longint'(c[5]);
        ox = longint'(c[0]) - longint'(c[4]);
        oy = longint'(c[1]) - longint'(c[5]);
        d = dyc * dxs - dxc * dys;
        n1 = dxc * oy - dyc * ox;
        n2 = dxs * oy - dys * ox;
        mag = (d < 0) ? -d : d;
        if (mag > longint'(limit_reg))
        begin
            if (d < 0)
            begin
                d = -d;
                n1 = -n1;
                n2 = -n2;
            end
            if (n1 >= 0 && n2 >= 0 && n1 <= d && n2 <= d)
            begin
                inner = n1 > 0 && n1 < d && n2 > 0 && n2 < d;
                o.hit = 1'b1;
                o.interior = inner;
                o.cross_x = 24'(interp_axis(c[0], dxs, n1, d));
                o.cross_y = 24'(interp_axis(c[1], dys, n1, d));
                o.t_source = 17'(scaled_round(n1, 65536, d));
                o.t_clip = 17'(scaled_round(n2, 65536, d));
            end
        end
        pending = {pending, o};
    endfunction

    // Compare one result against the oldest expectation.
    function void check_result(outcome_t got);
        outcome_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (want.hit)
            hits++;
        if (want.interior)
            interiors++;
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d expected %p got %p", checked, want, got);
        end
    endfunction
endclass

module tb_top;
    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [19:0] cfg_wdata;
    bit quiet_phase;
    bit hold_off;
    int sent;

    intersect_scoreboard sb;

    siu_seg_if #(.COORD_BITS(24)) seg ();
    siu_res_if #(.COORD_BITS(24), .T_FRAC_BITS(16)) res ();

    segment_intersection_unit_top #(.COORD_BITS(24), .T_FRAC_BITS(16)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .seg      (seg.sink),
        .res      (res.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop on a hung run.
    initial
    begin
        #2000000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    // Drive the result ready with random stalls and one long hold-off.
    initial
    begin
        int gap;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 4);
                res.ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                res.ready <= 1'b1;
        end
    end

    // Check each accepted result.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            sb.check_result({res.hit, res.interior, res.cross_x, res.cross_y,
                             res.t_source, res.t_clip});
    end

    // Offer one segment pair and hold it until accepted.
    task automatic send_pair(logic signed [23:0] c[8]);
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            seg.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        seg.valid <= 1'b1;
        seg.src_start_x <= c[0];
        seg.src_start_y <= c[1];
        seg.src_end_x <= c[2];
        seg.src_end_y <= c[3];
        seg.clip_start_x <= c[4];
        seg.clip_start_y <= c[5];
        seg.clip_end_x <= c[6];
        seg.clip_end_y <= c[7];
        do
            @(posedge clk);
        while (!seg.ready);
        sb.note_pair(c);
        sent++;
    endtask

    // Lower valid and wait for every expected result plus the pipeline depth.
    task automatic drain();
        seg.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(logic [19:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.limit_reg = v;
    endtask

    function automatic logic signed [23:0] rand_coord(int span);
        if (span == 0)
            return 24'($urandom);
        return 24'($urandom_range(0, 2 * span) - span);
    endfunction

    // Random pair: mostly crossing segments around a shared point, some parallel or with a shared endpoint, rest noise.
    task automatic send_random(int span);
        logic signed [23:0] c[8];
        int kind;
        longint px, py;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
            c[i] = rand_coord(span);
        if (kind < 6 && span != 0)
        begin
            px = rand_coord(span / 2);
            py = rand_coord(span / 2);
            c[2] = 24'(2 * px - c[0]);
            c[3] = 24'(2 * py - c[1]);
            c[6] = 24'(2 * px - c[4]);
            c[7] = 24'(2 * py - c[5]);
        end
        else if (kind == 6)
        begin
            // parallel or nearly so
            c[6] = c[4] + (c[2] - c[0]);
            c[7] = c[5] + (c[3] - c[1]) + 24'($urandom_range(0, 2));
        end
        else if (kind == 7)
        begin
            // shared endpoint
            c[4] = c[2];
            c[5] = c[3];
        end
        send_pair(c);
    endtask

    initial
    begin
        logic signed [23:0] c[8];
        logic signed [23:0] mx, mn;
        int spans[4];
        mx = 24'sh7FFFFF;
        mn = 24'sh800000;
        spans = '{0, 256, 65536, 4194303};
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        seg.valid = 1'b0;
        seg.src_start_x = '0;
        seg.src_start_y = '0;
        seg.src_end_x = '0;
        seg.src_end_y = '0;
        seg.clip_start_x = '0;
        seg.clip_start_y = '0;
        seg.clip_end_x = '0;
        seg.clip_end_y = '0;
        quiet_phase = 1'b0;
        hold_off = 1'b0;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: crossing, touching ends, parallel, degenerate, extremes.
        c = '{0, 0, 512, 512, 0, 512, 512, 0};
        send_pair(c);
        c = '{0, 0, 256, 0, 256, 0, 256, 256};
        send_pair(c);
        c = '{0, 0, 256, 0, 0, 0, 0, 256};
        send_pair(c);
        c = '{0, 0, 256, 256, 0, 256, 256, 512};
        send_pair(c);
        c = '{0, 0, 0, 0, 0, 0, 0, 0};
        send_pair(c);
        c = '{0, 0, 256, 0, 512, -256, 512, 256};
        send_pair(c);
        c = '{mn, mn, mx, mx, mn, mx, mx, mn};
        send_pair(c);
        c = '{mx, mn, mn, mx, mx, mx, mn, mn};
        send_pair(c);
        c = '{mn, 0, mx, 0, 0, mn, 0, mx};
        send_pair(c);
        c = '{mx, mx, mx, mx, mn, mn, mn, mn};
        send_pair(c);
        c = '{0, 0, 3, 0, 1, -1, 1, 2};
        send_pair(c);
        c = '{0, 0, -3, 7, -1, 5, 0, -4};
        send_pair(c);
        c = '{0, 0, 1, 1, 0, 1, 1, 0};
        send_pair(c);
        drain();

        // Limit extremes against small and large denominators.
        write_limit(20'hFFFFF);
        c = '{0, 0, 512, 512, 0, 512, 512, 0};
        send_pair(c);
        c = '{0, 0, 2048, 2048, 0, 2048, 2048, 0};
        send_pair(c);
        c = '{0, 0, 1, 1, 0, 1, 1, 0};
        send_pair(c);
        c = '{mn, mn, mx, mx, mn, mx, mx, mn};
        send_pair(c);
        drain();
        write_limit(20'd2);
        send_pair('{0, 0, 1, 1, 0, 1, 1, 0});
        send_pair('{0, 0, 2, 1, 0, 1, 1, 0});
        drain();

        // Random phases over several limit settings and coordinate spans.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_limit(20'd0);
                1: write_limit(20'($urandom_range(1, 1000)));
                2: write_limit(20'hFFFFF);
                3: write_limit(20'($urandom));
                4: write_limit(20'd0);
                default: write_limit(20'd1);
            endcase
            if (ph == 1)
                hold_off = 1'b1;
            if (ph == 5)
                quiet_phase = 1'b1;
            for (int i = 0; i < 240; i++)
                send_random(spans[$urandom_range(0, 3)]);
            drain();
        end

        $display("Ran %0d segment pairs, %0d results checked, %0d hits, %0d interior.",
                 sent, sb.checked, sb.hits, sb.interiors);
        $display("Limit settings covered zero, one, small, random and full scale.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("mismatches: %0d", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
